// File: design/wcg_pkg.sv
// Shared types and constants for the window coefficient generator.
`default_nettype none
package wcg_pkg;

  localparam int IDX_W      = 16;
  localparam int LEN_W      = 17;
  localparam int KIND_W     = 2;
  localparam int COEF_W     = 16;
  localparam int PHASE_W    = 24;
  localparam int U_W        = 23;
  localparam int X_W        = 31;
  localparam int X2_W       = 32;
  localparam int T_W        = 31;
  localparam int RECIP_W    = 33;
  localparam int DIVK_W     = 7;
  localparam int NUM_HORNER = 5;

  localparam logic [LEN_W-1:0] MAX_LENGTH = 17'd65536;
  localparam logic [LEN_W-1:0] RESET_LENGTH = 17'd1024;

  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [0:0] REG_WINDOW_KIND   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_BOXCAR  = 2'd0,
    KIND_HANN    = 2'd1,
    KIND_HAMMING = 2'd2
  } wcg_kind_e;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [T_W-1:0] ONE_Q30 = 31'd1073741824;
  localparam logic [29:0] HANN_A0 = 30'd536870912;
  localparam logic [29:0] HANN_A1 = 30'd536870912;
  localparam logic [29:0] HAMM_A0 = 30'd578059647;
  localparam logic [29:0] HAMM_A1 = 30'd495682177;

  localparam logic [COEF_W-1:0] COEF_ONE = 16'd32768;

  // Horner divisors and their reciprocals floor(2^33 / k)
  localparam logic [DIVK_W-1:0] HORNER_K [NUM_HORNER] = '{
    7'd90, 7'd56, 7'd30, 7'd12, 7'd2
  };
  localparam logic [RECIP_W-1:0] HORNER_M [NUM_HORNER] = '{
    33'd95443717, 33'd153391689, 33'd286331153, 33'd715827882, 33'd4294967296
  };

  typedef struct packed {
    logic              oor;
    logic [KIND_W-1:0] kind;
    logic              neg;
  } wcg_ctl_t;

endpackage
`default_nettype wire

// File: design/wcg_div_cell.sv
// One restoring division step: produces one phase bit per cell.
`default_nettype none
module wcg_div_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        en_i,
  input  wire                        valid_i,
  input  wire  [wcg_pkg::LEN_W-1:0]   rem_i,
  input  wire  [wcg_pkg::PHASE_W-1:0] quo_i,
  input  wire  [wcg_pkg::LEN_W-1:0]   len_i,
  input  wire  wcg_pkg::wcg_ctl_t     ctl_i,
  output logic                       valid_o,
  output logic [wcg_pkg::LEN_W-1:0]   rem_o,
  output logic [wcg_pkg::PHASE_W-1:0] quo_o,
  output logic [wcg_pkg::LEN_W-1:0]   len_o,
  output wcg_pkg::wcg_ctl_t           ctl_o
);
  import wcg_pkg::*;

  logic [LEN_W:0]   rem2;
  logic             ge;
  logic [LEN_W-1:0] rem_d;

  assign rem2  = {rem_i, 1'b0};
  assign ge    = rem2 >= {1'b0, len_i};
  assign rem_d = ge ? LEN_W'(rem2 - {1'b0, len_i}) : rem2[LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      quo_o <= {quo_i[PHASE_W-2:0], ge};
      len_o <= len_i;
      ctl_o <= ctl_i;
    end
  end

endmodule
`default_nettype wire

// File: design/wcg_horner_cell.sv
// One Horner step of the cosine series: t = 1 - (x2 * t) / k, three stages.
`default_nettype none
module wcg_horner_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire  [wcg_pkg::DIVK_W-1:0]    k_i,
  input  wire  [wcg_pkg::RECIP_W-1:0]   recip_i,
  input  wire                          valid_i,
  input  wire  [wcg_pkg::X2_W-1:0]      x2_i,
  input  wire  [wcg_pkg::T_W-1:0]       t_i,
  input  wire  wcg_pkg::wcg_ctl_t       ctl_i,
  output logic                         valid_o,
  output logic [wcg_pkg::X2_W-1:0]      x2_o,
  output logic [wcg_pkg::T_W-1:0]       t_o,
  output wcg_pkg::wcg_ctl_t             ctl_o
);
  import wcg_pkg::*;

  logic                    va_q, vb_q;
  logic [X2_W-1:0]         ya_q, yb_q, x2a_q, x2b_q;
  logic [X2_W-1:0]         qb_q;
  wcg_ctl_t                ctla_q, ctlb_q;

  logic [X2_W+T_W-1:0]     prod_y;
  logic [X2_W+RECIP_W-1:0] prod_q;
  logic [X2_W+DIVK_W-1:0]  qk;
  logic [X2_W+DIVK_W-1:0]  rem;
  logic [X2_W-1:0]         d;
  logic [T_W-1:0]          t_d;

  assign prod_y = x2_i * t_i;
  assign prod_q = ya_q * recip_i;

  // reciprocal estimate is at most one short; fix it with the remainder
  always_comb begin
    qk  = qb_q * k_i;
    rem = {{DIVK_W{1'b0}}, yb_q} - qk;
    d   = qb_q + X2_W'(rem >= (X2_W+DIVK_W)'(k_i));
    t_d = (d >= X2_W'(ONE_Q30)) ? '0 : T_W'(X2_W'(ONE_Q30) - d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      va_q    <= valid_i;
      vb_q    <= va_q;
      valid_o <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ya_q   <= prod_y[X2_W+29:30];
      x2a_q  <= x2_i;
      ctla_q <= ctl_i;
      qb_q   <= prod_q[X2_W+RECIP_W-1:RECIP_W];
      yb_q   <= ya_q;
      x2b_q  <= x2a_q;
      ctlb_q <= ctla_q;
      t_o    <= t_d;
      x2_o   <= x2b_q;
      ctl_o  <= ctlb_q;
    end
  end

endmodule
`default_nettype wire

// File: design/window_coefficient_generator.sv
// Top level of the window coefficient generator: phase divider, cosine and output stage.
// Returns one Hann, Hamming or boxcar weight (unsigned Q1.15) per sample index and
// accepts one index every clock while s_axis_tready is high. On its way to the output
// register each result passes one input register, 24 divider cells (one phase bit
// each), a fold stage, two angle multiplier stages, five Horner cells of three stages,
// and two weighting stages ahead of the output register. A two-entry output register
// with skid lets the block keep taking input while one result waits; when both entries
// are full, s_axis_tready drops.
// window_length and window_kind are sampled per item at the input.
`default_nettype none
module window_coefficient_generator (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire  [15:0]                 s_axis_tdata,   // [15:0] sample_index
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  output logic [15:0]                 m_axis_tdata,   // [15:0] coefficient
  output logic                        m_axis_tuser,   // [0] out_of_range
  input  wire                         cfg_we_i,
  input  wire  [0:0]                  cfg_index_i,
  input  wire  [wcg_pkg::LEN_W-1:0]   cfg_data_i
);
  import wcg_pkg::*;

  localparam int DIV_STEPS = PHASE_W;

  logic              en;
  logic [LEN_W-1:0]  len_q;
  logic [KIND_W-1:0] kind_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= RESET_LENGTH;
      kind_q <= KIND_BOXCAR;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WINDOW_LENGTH: len_q  <= cfg_data_i;
        REG_WINDOW_KIND:   kind_q <= cfg_data_i[KIND_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic [LEN_W-1:0] len_eff;
  logic             in_valid_q;
  logic [LEN_W-1:0] in_rem_q, in_len_q;
  wcg_ctl_t         in_ctl_q;

  assign len_eff = (len_q > MAX_LENGTH) ? MAX_LENGTH : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_rem_q      <= LEN_W'(s_axis_tdata);
      in_len_q      <= len_eff;
      in_ctl_q.oor  <= LEN_W'(s_axis_tdata) >= len_eff;
      in_ctl_q.kind <= kind_q;
      in_ctl_q.neg  <= 1'b0;
    end
  end

  // phase divider chain
  logic                div_valid [DIV_STEPS+1];
  logic [LEN_W-1:0]    div_rem   [DIV_STEPS+1];
  logic [PHASE_W-1:0]  div_quo   [DIV_STEPS+1];
  logic [LEN_W-1:0]    div_len   [DIV_STEPS+1];
  wcg_ctl_t            div_ctl   [DIV_STEPS+1];

  assign div_valid[0] = in_valid_q;
  assign div_rem[0]   = in_rem_q;
  assign div_quo[0]   = '0;
  assign div_len[0]   = in_len_q;
  assign div_ctl[0]   = in_ctl_q;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    wcg_div_cell u_div_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_valid[g]),
      .rem_i   (div_rem[g]),
      .quo_i   (div_quo[g]),
      .len_i   (div_len[g]),
      .ctl_i   (div_ctl[g]),
      .valid_o (div_valid[g+1]),
      .rem_o   (div_rem[g+1]),
      .quo_o   (div_quo[g+1]),
      .len_o   (div_len[g+1]),
      .ctl_o   (div_ctl[g+1])
    );
  end

  // fold the phase into the first quadrant
  logic [PHASE_W-1:0] p_raw, p_fold;
  logic               neg;
  logic [U_W-1:0]     u;
  wcg_ctl_t           f_ctl_d;

  always_comb begin
    p_raw  = div_quo[DIV_STEPS];
    p_fold = (p_raw > PHASE_W'(1 << (PHASE_W-1))) ? PHASE_W'(~p_raw + 1'b1) : p_raw;
    neg    = p_fold > PHASE_W'(1 << (PHASE_W-2));
    u      = neg ? U_W'(PHASE_W'(1 << (PHASE_W-1)) - p_fold) : p_fold[U_W-1:0];
    f_ctl_d     = div_ctl[DIV_STEPS];
    f_ctl_d.neg = neg;
  end

  logic            f_valid_q, x_valid_q, s_valid_q;
  logic [U_W-1:0]  f_u_q;
  logic [X_W-1:0]  x_q;
  logic [X2_W-1:0] x2_q;
  wcg_ctl_t        f_ctl_q, x_ctl_q, s_ctl_q;
  logic [U_W+31:0] prod_x;
  logic [2*X_W-1:0] prod_x2;

  assign prod_x  = f_u_q * PI_Q30;
  assign prod_x2 = x_q * x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      x_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= div_valid[DIV_STEPS];
      x_valid_q <= f_valid_q;
      s_valid_q <= x_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_u_q        <= u;
      f_ctl_q      <= f_ctl_d;
      x_q          <= prod_x[X_W+22:23];
      x_ctl_q      <= f_ctl_q;
      x2_q         <= prod_x2[X2_W+29:30];
      s_ctl_q      <= x_ctl_q;
    end
  end

  // Horner chain for the cosine magnitude
  logic            h_valid [NUM_HORNER+1];
  logic [X2_W-1:0] h_x2    [NUM_HORNER+1];
  logic [T_W-1:0]  h_t     [NUM_HORNER+1];
  wcg_ctl_t        h_ctl   [NUM_HORNER+1];

  assign h_valid[0] = s_valid_q;
  assign h_x2[0]    = x2_q;
  assign h_t[0]     = ONE_Q30;
  assign h_ctl[0]   = s_ctl_q;

  for (genvar h = 0; h < NUM_HORNER; h++) begin : g_horner
    wcg_horner_cell u_horner_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .k_i     (HORNER_K[h]),
      .recip_i (HORNER_M[h]),
      .valid_i (h_valid[h]),
      .x2_i    (h_x2[h]),
      .t_i     (h_t[h]),
      .ctl_i   (h_ctl[h]),
      .valid_o (h_valid[h+1]),
      .x2_o    (h_x2[h+1]),
      .t_o     (h_t[h+1]),
      .ctl_o   (h_ctl[h+1])
    );
  end

  // weighting
  logic             is_hamm;
  logic [29:0]      a1;
  logic [30+T_W-1:0] prod_m;
  logic             m_valid_q;
  logic [T_W-1:0]   m_q;
  wcg_ctl_t         m_ctl_q;

  assign is_hamm = h_ctl[NUM_HORNER].kind == KIND_HAMMING;
  assign a1      = is_hamm ? HAMM_A1 : HANN_A1;
  assign prod_m  = a1 * h_t[NUM_HORNER];

  logic [29:0]       a0;
  logic [31:0]       w;
  logic [32:0]       wr;
  logic [COEF_W-1:0] coef;

  always_comb begin
    a0 = (m_ctl_q.kind == KIND_HAMMING) ? HAMM_A0 : HANN_A0;
    if (m_ctl_q.neg) begin
      w = 32'(a0) + 32'(m_q);
    end else if (32'(m_q) > 32'(a0)) begin
      w = '0;
    end else begin
      w = 32'(a0) - 32'(m_q);
    end
    wr = 33'(w) + 33'(1 << 14);
    if (m_ctl_q.oor) begin
      coef = '0;
    end else if (m_ctl_q.kind != KIND_HANN && m_ctl_q.kind != KIND_HAMMING) begin
      coef = COEF_ONE;
    end else if (wr[32:15] > 18'(COEF_ONE)) begin
      coef = COEF_ONE;
    end else begin
      coef = wr[30:15];
    end
  end

  logic              p_valid_q;
  logic [COEF_W-1:0] p_coef_q;
  logic              p_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= h_valid[NUM_HORNER];
      p_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q      <= prod_m[30+T_W-1:30];
      m_ctl_q  <= h_ctl[NUM_HORNER];
      p_coef_q <= coef;
      p_oor_q  <= m_ctl_q.oor;
    end
  end

  // output register with skid entry
  logic              o_valid_q, k_valid_q;
  logic [COEF_W-1:0] o_coef_q, k_coef_q;
  logic              o_oor_q, k_oor_q;
  logic              o_free;

  assign en     = ~k_valid_q;
  assign o_free = ~o_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      k_valid_q <= 1'b0;
    end else if (o_free) begin
      if (k_valid_q) begin
        o_valid_q <= 1'b1;
        k_valid_q <= 1'b0;
      end else begin
        o_valid_q <= p_valid_q;
      end
    end else if (p_valid_q && en) begin
      k_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_free) begin
      o_coef_q <= k_valid_q ? k_coef_q : p_coef_q;
      o_oor_q  <= k_valid_q ? k_oor_q : p_oor_q;
    end else if (p_valid_q && en) begin
      k_coef_q <= p_coef_q;
      k_oor_q  <= p_oor_q;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_coef_q;
  assign m_axis_tuser  = o_oor_q;

endmodule
`default_nettype wire

// File: design/wcg_checker.sv
// Port-level checks for the window coefficient generator, bound to the top level.
`default_nettype none
module wcg_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [15:0] m_axis_tdata,
  input wire        m_axis_tuser
);

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 16'd0))
    else $error("out of range result with nonzero coefficient");

  a_coef_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= 16'd32768))
    else $error("coefficient above 1.0");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind window_coefficient_generator wcg_checker u_wcg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// File: tb/sv/window_coefficient_generator_tb.sv
// Self-checking testbench for the window coefficient generator.
`timescale 1ns / 1ps
module window_coefficient_generator_tb;
  import wcg_pkg::*;

  class coef_scoreboard;
    logic [LEN_W-1:0] length;
    logic [KIND_W-1:0] kind;
    logic [16:0] pending[$];
    int errors;
    int checked;

    function new();
      length = RESET_LENGTH;
      kind = KIND_BOXCAR;
      errors = 0;
      checked = 0;
    endfunction

    function logic [63:0] cos_mag(logic [63:0] u);
      logic [63:0] x, x2, t, d;
      int divs[5];
      divs = '{90, 56, 30, 12, 2};
      x = (u * 64'd3373259426) >> 23;
      x2 = (x * x) >> 30;
      t = 64'd1 << 30;
      foreach (divs[j]) begin
        d = ((x2 * t) >> 30) / divs[j];
        t = (d >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - d;
      end
      return t;
    endfunction

    // {out_of_range, coefficient}
    function logic [16:0] weight(logic [15:0] idx);
      logic [63:0] n, p, u, c, m, w, a0, a1, q;
      logic neg;
      n = length;
      if (n > 65536) n = 65536;
      if (idx >= n) return {1'b1, 16'd0};
      if (kind != KIND_HANN && kind != KIND_HAMMING) return {1'b0, COEF_ONE};
      p = ((64'(idx) << 24) / n) & 64'hFFFFFF;
      if (p > (64'd1 << 23)) p = (64'd1 << 24) - p;
      neg = p > (64'd1 << 22);
      u = neg ? (64'd1 << 23) - p : p;
      c = cos_mag(u);
      a0 = (kind == KIND_HANN) ? 64'd536870912 : 64'd578059647;
      a1 = (kind == KIND_HANN) ? 64'd536870912 : 64'd495682177;
      m = (a1 * c) >> 30;
      if (neg) w = a0 + m;
      else w = (m > a0) ? 64'd0 : a0 - m;
      q = (w + (64'd1 << 14)) >> 15;
      if (q > 32768) q = 32768;
      return {1'b0, q[15:0]};
    endfunction

    function void note_index(logic [15:0] idx);
      pending = {pending, weight(idx)};
    endfunction

    function void check_coef(logic [15:0] coef, logic oor);
      logic [16:0] exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result coef=%0d oor=%0d", $time, coef, oor);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      checked++;
      if (exp_w[15:0] !== coef) begin
        $display("%0t: coefficient expected %0d actual %0d", $time, exp_w[15:0], coef);
        errors++;
      end
      if (exp_w[16] !== oor) begin
        $display("%0t: out_of_range expected %0d actual %0d", $time, exp_w[16], oor);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = REG_WINDOW_LENGTH;
  logic [LEN_W-1:0] cfg_data_i = '0;

  coef_scoreboard sb = new();
  bit stall_off;

  always #5 clk_i = ~clk_i;

  window_coefficient_generator u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Receiver: random stalls, check every transaction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_coef(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    int g;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      m_axis_tready <= 1'b1;
      g = stall_off ? 0 : gap_len();
      if (g > 0) begin
        @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (g - 1) @(posedge clk_i);
      end
    end
  end

  // Hold tvalid across back-to-back transactions; drop it only for a gap.
  task automatic send_index(logic [15:0] idx);
    int g;
    g = stall_off ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= idx;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_index(idx);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [LEN_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) sb.length = val;
    else sb.kind = val[KIND_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    logic [LEN_W-1:0] lens[8];
    logic [LEN_W-1:0] n;
    int k;
    lens = '{17'd1, 17'd2, 17'd1024, 17'd65536, 17'd0, 17'd131071, 17'd7, 17'd65535};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config, extremes, quarter points, each kind.
    send_index(16'd0);
    send_index(16'd1023);
    send_index(16'd1024);
    send_index(16'hFFFF);
    drain();
    for (int kd = 0; kd < 4; kd++) begin
      write_reg(REG_WINDOW_KIND, LEN_W'(kd));
      write_reg(REG_WINDOW_LENGTH, 17'd16);
      foreach (lens[j]) if (j < 5) send_index(16'(j * 4));
      send_index(16'd15);
      drain();
    end

    // Random phases: cycle lengths and kinds, mostly in-range indices.
    for (int ph = 0; ph < 24; ph++) begin
      n = (ph < 8) ? lens[ph] : LEN_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ?
            131071 : 300));
      write_reg(REG_WINDOW_LENGTH, n);
      write_reg(REG_WINDOW_KIND, LEN_W'($urandom_range(0, 3)));
      stall_off = (ph % 6 == 5);
      for (int j = 0; j < 50; j++) begin
        k = $urandom_range(0, 9);
        if (k == 0 || n == 0) send_index(16'($urandom()));
        else if (k == 1) send_index(16'(n > 65536 ? 65535 : n - 1));
        else send_index(16'($urandom_range(0, (n > 65536 ? 65536 : n) - 1)));
      end
      stall_off = 0;
      drain();
    end

    $display("Checked %0d coefficients over boxcar, hann, hamming and unused kind,",
             sb.checked);
    $display("window lengths from zero past the maximum, with random stalls.");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("window_coefficient_generator verification clean");
    else
      $display("window_coefficient_generator verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("window_coefficient_generator verification failed");
    $finish;
  end
endmodule
